/* rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam int ORDER_COUNT = 11;
	localparam int TOP_ORDER   = ORDER_COUNT - 1;
	localparam int POOL_SIZE   = 8192;
	localparam int MAX_BLOCK   = 1 << TOP_ORDER;
	localparam int MARK_DEPTH  = 2 * POOL_SIZE;
	localparam int WORD_BITS   = 64;
	localparam int WORD_COUNT  = MARK_DEPTH / WORD_BITS;
	localparam int ORD_W       = 4;
	localparam int IDX_W       = 13;
	localparam int CNT_W       = 14;
	localparam int PAGES_W     = 11;
	localparam int POS_W       = $clog2(MARK_DEPTH);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WADDR_W     = POS_W - BIT_W;
	localparam int COUNT_MAX   = (1 << CNT_W) - 1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [1:0] STATUS_BAD     = 2'd2;

	localparam int OP_W = 5;
	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_NONE       = 5'd0;
	localparam op_t OP_CLEAR      = 5'd1;
	localparam op_t OP_CARVE      = 5'd2;
	localparam op_t OP_READ       = 5'd3;
	localparam op_t OP_SET        = 5'd4;
	localparam op_t OP_ACCEPT     = 5'd5;
	localparam op_t OP_SCAN_INIT  = 5'd6;
	localparam op_t OP_SCAN_READ  = 5'd7;
	localparam op_t OP_SCAN_NEXT  = 5'd8;
	localparam op_t OP_ORDER_NEXT = 5'd9;
	localparam op_t OP_TAKE       = 5'd10;
	localparam op_t OP_SPLIT      = 5'd11;
	localparam op_t OP_PROBE_INIT = 5'd12;
	localparam op_t OP_PROBE_NEXT = 5'd13;
	localparam op_t OP_MERGE_INIT = 5'd14;
	localparam op_t OP_BUDDY      = 5'd15;
	localparam op_t OP_MERGE      = 5'd16;
	localparam op_t OP_HOME       = 5'd17;
	localparam op_t OP_DONE_OK    = 5'd18;
	localparam op_t OP_DONE_FULL  = 5'd19;
	localparam op_t OP_DONE_BAD   = 5'd20;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic bad;
		logic misfit;
		logic carve_more;
		logic clear_last;
		logic hit;
		logic scan_last;
		logic top;
		logic split_more;
		logic mark;
		logic out_free;
	} stat_t;

	function automatic logic [POS_W-1:0] mark_base(input logic [ORD_W-1:0] o);
		return POS_W'(MARK_DEPTH - (MARK_DEPTH >> o));
	endfunction

	function automatic logic [WADDR_W-1:0] word_first(input logic [ORD_W-1:0] o);
		logic [POS_W-1:0] b;
		b = mark_base(o);
		return b[POS_W-1:BIT_W];
	endfunction

	function automatic logic [WADDR_W-1:0] word_last(input logic [ORD_W-1:0] o);
		logic [POS_W-1:0] e;
		e = mark_base(o + ORD_W'(1)) - POS_W'(1);
		return e[POS_W-1:BIT_W];
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > (CNT_W + 1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] floor_sub(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

`default_nettype wire

/* rtl/bpa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/bpa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpa_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CNT_W-1:0]      cfg_wdata,
	input  logic                           command,
	input  logic [bpa_pkg::CNT_W-1:0]      page_count,
	input  logic [bpa_pkg::IDX_W-1:0]      page_index,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [1:0]                     status,
	output logic [bpa_pkg::IDX_W-1:0]      block_index,
	output logic [bpa_pkg::PAGES_W-1:0]    block_pages,
	output logic [bpa_pkg::CNT_W-1:0]      pages_free,
	input  bpa_pkg::cmd_t                  cmd,
	output bpa_pkg::stat_t                 stat
);

	localparam int CW = bpa_pkg::CNT_W;
	localparam int IW = bpa_pkg::IDX_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam int PW = bpa_pkg::POS_W;
	localparam int BW = bpa_pkg::BIT_W;
	localparam int AW = bpa_pkg::WADDR_W;
	localparam int DW = bpa_pkg::WORD_BITS;

	logic [CW-1:0] pool_q, total_q, addr_q;
	logic [AW-1:0] wptr_q;
	logic          out_valid_q;
	logic [OW-1:0] tord_q, need_q;
	logic [IW-1:0] tgt_q, blk_q, idx_q;
	logic          is_free_q, bad_q, misfit_q;
	logic [1:0]    status_q;
	logic [IW-1:0] bidx_q;
	logic [bpa_pkg::PAGES_W-1:0] bpages_q;
	logic [CW-1:0] fpages_q;

	logic [CW-1:0] lim, size_in, tord_pages;
	logic [OW-1:0] need_in, carve_o;
	logic          bad_in, misfit_in;
	logic [PW-1:0] pos, lo, hi, found_pos, found_blk;
	logic [DW-1:0] rdata, wdata, masked, bitmask;
	logic [AW-1:0] waddr, raddr;
	logic          we;
	logic [BW-1:0] lsb;
	logic [IW-1:0] found_idx;

	assign lim = (pool_q > CW'(bpa_pkg::POOL_SIZE)) ? CW'(bpa_pkg::POOL_SIZE) : pool_q;

	always_comb begin
		need_in = OW'(bpa_pkg::TOP_ORDER);
		for (int k = bpa_pkg::TOP_ORDER; k >= 0; k--) begin
			if ((CW + 1)'(1 << k) >= {1'b0, page_count}) begin
				need_in = OW'(k);
			end
		end
	end

	assign bad_in    = (page_count == '0) || (page_count > CW'(bpa_pkg::MAX_BLOCK));
	assign size_in   = CW'(1) << need_in;
	assign misfit_in = ((CW'(page_index) & (size_in - CW'(1))) != '0)
		|| ((CW + 1)'(page_index) + (CW + 1)'(size_in) > (CW + 1)'(lim));

	always_comb begin
		carve_o = '0;
		for (int k = 0; k <= bpa_pkg::TOP_ORDER; k++) begin
			if (((addr_q & CW'((1 << k) - 1)) == '0)
					&& ((CW + 1)'(addr_q) + (CW + 1)'(1 << k) <= (CW + 1)'(lim))) begin
				carve_o = OW'(k);
			end
		end
	end

	assign tord_pages = CW'(1) << tord_q;
	assign pos        = bpa_pkg::mark_base(tord_q) + PW'(tgt_q >> tord_q);
	assign bitmask    = DW'(1) << pos[BW-1:0];
	assign lo         = bpa_pkg::mark_base(tord_q);
	assign hi         = bpa_pkg::mark_base(tord_q + OW'(1));

	always_comb begin
		masked = '0;
		for (int j = 0; j < DW; j++) begin
			masked[j] = rdata[j] && ({wptr_q, BW'(j)} >= lo) && ({wptr_q, BW'(j)} < hi);
		end
	end

	always_comb begin
		lsb = '0;
		for (int j = DW - 1; j >= 0; j--) begin
			if (masked[j]) begin
				lsb = BW'(j);
			end
		end
	end

	assign found_pos = {wptr_q, lsb};
	assign found_blk = found_pos - lo;
	assign found_idx = IW'(found_blk << tord_q);

	assign raddr = (cmd.op == bpa_pkg::OP_SCAN_READ) ? wptr_q : pos[PW-1:BW];

	always_comb begin
		we    = 1'b0;
		waddr = wptr_q;
		wdata = '0;
		unique case (cmd.op)
			bpa_pkg::OP_CLEAR: begin
				we = 1'b1;
			end
			bpa_pkg::OP_SET: begin
				we    = 1'b1;
				waddr = pos[PW-1:BW];
				wdata = rdata | bitmask;
			end
			bpa_pkg::OP_MERGE: begin
				we    = 1'b1;
				waddr = pos[PW-1:BW];
				wdata = rdata & ~bitmask;
			end
			bpa_pkg::OP_TAKE: begin
				we    = 1'b1;
				wdata = rdata & ~(DW'(1) << lsb);
			end
			default: begin
			end
		endcase
	end

	bpa_ram #(
		.WIDTH(DW),
		.DEPTH(bpa_pkg::WORD_COUNT)
	) u_mark_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= '0;
			total_q     <= '0;
			wptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
				wptr_q <= '0;
			end else begin
				unique case (cmd.op)
					bpa_pkg::OP_CLEAR: begin
						wptr_q  <= wptr_q + AW'(1);
						total_q <= '0;
					end
					bpa_pkg::OP_SET: total_q <= bpa_pkg::sat_add(total_q, tord_pages);
					bpa_pkg::OP_TAKE, bpa_pkg::OP_MERGE: begin
						total_q <= bpa_pkg::floor_sub(total_q, tord_pages);
					end
					bpa_pkg::OP_SCAN_INIT: wptr_q <= bpa_pkg::word_first(need_q);
					bpa_pkg::OP_SCAN_NEXT: wptr_q <= wptr_q + AW'(1);
					bpa_pkg::OP_ORDER_NEXT: wptr_q <= bpa_pkg::word_first(tord_q + OW'(1));
					default: begin
					end
				endcase
			end
			if (cmd.op == bpa_pkg::OP_DONE_OK || cmd.op == bpa_pkg::OP_DONE_FULL
					|| cmd.op == bpa_pkg::OP_DONE_BAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bpa_pkg::OP_CLEAR: addr_q <= '0;
			bpa_pkg::OP_CARVE: begin
				tord_q <= carve_o;
				tgt_q  <= IW'(addr_q);
				addr_q <= addr_q + (CW'(1) << carve_o);
			end
			bpa_pkg::OP_ACCEPT: begin
				is_free_q <= command;
				need_q    <= need_in;
				bad_q     <= bad_in;
				misfit_q  <= misfit_in;
				idx_q     <= page_index;
			end
			bpa_pkg::OP_SCAN_INIT: tord_q <= need_q;
			bpa_pkg::OP_ORDER_NEXT: tord_q <= tord_q + OW'(1);
			bpa_pkg::OP_TAKE: blk_q <= found_idx;
			bpa_pkg::OP_SPLIT: begin
				tord_q <= tord_q - OW'(1);
				tgt_q  <= blk_q | (IW'(1) << (tord_q - OW'(1)));
			end
			bpa_pkg::OP_PROBE_INIT: begin
				tord_q <= need_q;
				tgt_q  <= idx_q;
			end
			bpa_pkg::OP_PROBE_NEXT: tord_q <= tord_q + OW'(1);
			bpa_pkg::OP_MERGE_INIT: begin
				tord_q <= need_q;
				blk_q  <= idx_q;
			end
			bpa_pkg::OP_BUDDY: tgt_q <= blk_q ^ (IW'(1) << tord_q);
			bpa_pkg::OP_MERGE: begin
				blk_q  <= blk_q & ~(IW'(1) << tord_q);
				tord_q <= tord_q + OW'(1);
			end
			bpa_pkg::OP_HOME: tgt_q <= blk_q;
			bpa_pkg::OP_DONE_OK: begin
				status_q <= bpa_pkg::STATUS_OK;
				bidx_q   <= blk_q;
				bpages_q <= bpa_pkg::PAGES_W'(1) << tord_q;
				fpages_q <= total_q;
			end
			bpa_pkg::OP_DONE_FULL: begin
				status_q <= bpa_pkg::STATUS_NOSPACE;
				bidx_q   <= '0;
				bpages_q <= '0;
				fpages_q <= total_q;
			end
			bpa_pkg::OP_DONE_BAD: begin
				status_q <= bpa_pkg::STATUS_BAD;
				bidx_q   <= '0;
				bpages_q <= '0;
				fpages_q <= total_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.is_free    = is_free_q;
	assign stat.bad        = bad_q;
	assign stat.misfit     = misfit_q;
	assign stat.carve_more = addr_q < lim;
	assign stat.clear_last = wptr_q == AW'(bpa_pkg::WORD_COUNT - 1);
	assign stat.hit        = masked != '0;
	assign stat.scan_last  = wptr_q == bpa_pkg::word_last(tord_q);
	assign stat.top        = tord_q == OW'(bpa_pkg::TOP_ORDER);
	assign stat.split_more = tord_q > need_q;
	assign stat.mark       = (rdata & bitmask) != '0;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = bidx_q;
	assign block_pages = bpages_q;
	assign pages_free  = fpages_q;

endmodule

`default_nettype wire

/* rtl/bpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           in_valid,
	output logic           in_ready,
	input  bpa_pkg::stat_t stat,
	output bpa_pkg::cmd_t  cmd
);

	localparam logic [4:0] S_CLEAR    = 5'd0;
	localparam logic [4:0] S_CARVE    = 5'd1;
	localparam logic [4:0] S_C_RD     = 5'd2;
	localparam logic [4:0] S_C_WR     = 5'd3;
	localparam logic [4:0] S_IDLE     = 5'd4;
	localparam logic [4:0] S_DISPATCH = 5'd5;
	localparam logic [4:0] S_S_RD     = 5'd6;
	localparam logic [4:0] S_S_CHK    = 5'd7;
	localparam logic [4:0] S_SPLIT    = 5'd8;
	localparam logic [4:0] S_SP_RD    = 5'd9;
	localparam logic [4:0] S_SP_WR    = 5'd10;
	localparam logic [4:0] S_P_RD     = 5'd11;
	localparam logic [4:0] S_P_CHK    = 5'd12;
	localparam logic [4:0] S_M_BUD    = 5'd13;
	localparam logic [4:0] S_M_RD     = 5'd14;
	localparam logic [4:0] S_M_CHK    = 5'd15;
	localparam logic [4:0] S_H_RD     = 5'd16;
	localparam logic [4:0] S_H_WR     = 5'd17;
	localparam logic [4:0] S_OK       = 5'd18;
	localparam logic [4:0] S_FULL     = 5'd19;
	localparam logic [4:0] S_BAD      = 5'd20;

	logic [4:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd.op   = bpa_pkg::OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = bpa_pkg::OP_CLEAR;
				if (stat.clear_last) begin
					state_d = S_CARVE;
				end
			end
			S_CARVE: begin
				if (stat.carve_more) begin
					cmd.op  = bpa_pkg::OP_CARVE;
					state_d = S_C_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_C_RD: begin
				cmd.op  = bpa_pkg::OP_READ;
				state_d = S_C_WR;
			end
			S_C_WR: begin
				cmd.op  = bpa_pkg::OP_SET;
				state_d = S_CARVE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = bpa_pkg::OP_ACCEPT;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.bad) begin
					state_d = S_BAD;
				end else if (stat.is_free) begin
					if (stat.misfit) begin
						state_d = S_BAD;
					end else begin
						cmd.op  = bpa_pkg::OP_PROBE_INIT;
						state_d = S_P_RD;
					end
				end else begin
					cmd.op  = bpa_pkg::OP_SCAN_INIT;
					state_d = S_S_RD;
				end
			end
			S_S_RD: begin
				cmd.op  = bpa_pkg::OP_SCAN_READ;
				state_d = S_S_CHK;
			end
			S_S_CHK: begin
				if (stat.hit) begin
					cmd.op  = bpa_pkg::OP_TAKE;
					state_d = S_SPLIT;
				end else if (!stat.scan_last) begin
					cmd.op  = bpa_pkg::OP_SCAN_NEXT;
					state_d = S_S_RD;
				end else if (stat.top) begin
					state_d = S_FULL;
				end else begin
					cmd.op  = bpa_pkg::OP_ORDER_NEXT;
					state_d = S_S_RD;
				end
			end
			S_SPLIT: begin
				if (stat.split_more) begin
					cmd.op  = bpa_pkg::OP_SPLIT;
					state_d = S_SP_RD;
				end else begin
					state_d = S_OK;
				end
			end
			S_SP_RD: begin
				cmd.op  = bpa_pkg::OP_READ;
				state_d = S_SP_WR;
			end
			S_SP_WR: begin
				cmd.op  = bpa_pkg::OP_SET;
				state_d = S_SPLIT;
			end
			S_P_RD: begin
				cmd.op  = bpa_pkg::OP_READ;
				state_d = S_P_CHK;
			end
			S_P_CHK: begin
				if (stat.mark) begin
					state_d = S_BAD;
				end else if (stat.top) begin
					cmd.op  = bpa_pkg::OP_MERGE_INIT;
					state_d = S_M_BUD;
				end else begin
					cmd.op  = bpa_pkg::OP_PROBE_NEXT;
					state_d = S_P_RD;
				end
			end
			S_M_BUD: begin
				if (stat.top) begin
					cmd.op  = bpa_pkg::OP_HOME;
					state_d = S_H_RD;
				end else begin
					cmd.op  = bpa_pkg::OP_BUDDY;
					state_d = S_M_RD;
				end
			end
			S_M_RD: begin
				cmd.op  = bpa_pkg::OP_READ;
				state_d = S_M_CHK;
			end
			S_M_CHK: begin
				if (stat.mark) begin
					cmd.op  = bpa_pkg::OP_MERGE;
					state_d = S_M_BUD;
				end else begin
					cmd.op  = bpa_pkg::OP_HOME;
					state_d = S_H_RD;
				end
			end
			S_H_RD: begin
				cmd.op  = bpa_pkg::OP_READ;
				state_d = S_H_WR;
			end
			S_H_WR: begin
				cmd.op  = bpa_pkg::OP_SET;
				state_d = S_OK;
			end
			S_OK: begin
				if (stat.out_free) begin
					cmd.op  = bpa_pkg::OP_DONE_OK;
					state_d = S_IDLE;
				end
			end
			S_FULL: begin
				if (stat.out_free) begin
					cmd.op  = bpa_pkg::OP_DONE_FULL;
					state_d = S_IDLE;
				end
			end
			S_BAD: begin
				if (stat.out_free) begin
					cmd.op  = bpa_pkg::OP_DONE_BAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (cfg_we) begin
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/buddy_page_allocator_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// config    cfg_we                  cfg_wdata (pool_pages)
// request   in_valid / in_ready     command, page_count, page_index
// result    out_valid / out_ready   status, block_index, block_pages, pages_free
//
// After reset and after every configuration write the free map is swept clean, one
// 64-bit word per cycle over all 256 words, then the pool is carved into blocks, each
// marked free by a read and a write of its free-map word. An allocation scans the free
// map word by word from the requested order upward and splits the block it takes. A free
// probes each order upward, then merges with free buddies; a bad request goes to its result.
// A result waiting in the output register does not stop the next request being accepted,
// but the following result waits in its final state until that register is taken.

module buddy_page_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bpa_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [bpa_pkg::CNT_W-1:0]   page_count,
	input  logic [bpa_pkg::IDX_W-1:0]   page_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [bpa_pkg::IDX_W-1:0]   block_index,
	output logic [bpa_pkg::PAGES_W-1:0] block_pages,
	output logic [bpa_pkg::CNT_W-1:0]   pages_free
);

	bpa_pkg::cmd_t  cmd;
	bpa_pkg::stat_t stat;

	bpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bpa_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.command    (command),
		.page_count (page_count),
		.page_index (page_index),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.block_index(block_index),
		.block_pages(block_pages),
		.pages_free (pages_free),
		.cmd        (cmd),
		.stat       (stat)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == bpa_pkg::OP_DONE_OK || cmd.op == bpa_pkg::OP_DONE_FULL
			|| cmd.op == bpa_pkg::OP_DONE_BAD) |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !cfg_we) |=> !in_ready)
		else $error("request accepted while the previous one is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == bpa_pkg::STATUS_OK || status == bpa_pkg::STATUS_NOSPACE
			|| status == bpa_pkg::STATUS_BAD))
		else $error("undefined status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bpa_pkg::STATUS_OK) |-> (block_pages != '0))
		else $error("successful result with an empty block");
`endif

endmodule

`default_nettype wire
